### rtl/spq_pkg.sv
// spq_pkg: shared constants, codes, types and key helpers of the sorted priority queue.
// No dependencies; every other file of the queue imports it.
package spq_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;
    localparam int FIELD_W   = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // operation codes
    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_COUNT   = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [1:0]           op_t;
    typedef logic [1:0]           status_t;
    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [FIELD_W-1:0]   field_t;
    typedef logic [CNT_W-1:0]     count_t;

    // what one cell shows to its neighbors
    typedef struct packed {
        logic   valid;
        logic   gt;
        key_t   key;
        field_t payload;
    } cell_t;

    // broadcast to all cells for the request being taken
    typedef struct packed {
        logic   enq;
        logic   deq;
        logic   clr;
        key_t   key;
        field_t payload;
    } cell_ctrl_t;

    // keep the low KEY_WIDTH bits of the 32-bit key field
    function automatic key_t key_from_field(input field_t f);
        logic [63:0] w;
        begin
            w = {32'b0, f};
            return w[KEY_WIDTH-1:0];
        end
    endfunction

    // stored key back to the 32-bit result field
    function automatic field_t key_to_field(input key_t k);
        logic [63:0] w;
        begin
            w = 64'(k);
            return w[FIELD_W-1:0];
        end
    endfunction

endpackage

### rtl/spq_if.sv
// spq_req_if / spq_rsp_if: valid/ready channels of the sorted priority queue.
// Depends on spq_pkg for the field types.
interface spq_req_if;
    import spq_pkg::*;

    logic   valid;
    logic   ready;
    op_t    operation;
    field_t item_key;
    field_t item_payload;

    modport source (output valid, output operation, output item_key, output item_payload,
                    input ready);
    modport sink   (input valid, input operation, input item_key, input item_payload,
                    output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    field_t  removed_key;
    field_t  removed_payload;
    count_t  occupancy;

    modport source (output valid, output status, output removed_key, output removed_payload,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input removed_key, input removed_payload,
                    input occupancy, output ready);
endinterface

### rtl/sorted_priority_queue_top.sv
// sorted_priority_queue_top: bounded priority queue built as a chain of compare/shift cells.
// Depends on spq_pkg, spq_if.sv and spq_cell.
//
// The queue holds up to CAPACITY key/payload entries in ascending key order,
// equal keys leaving in arrival order. For every request (enqueue, dequeue,
// count, clear) all cells compare the new key against their own in parallel
// and shift by one place in the same edge, so a new request is taken every
// cycle as long as the response register is free or being emptied. The
// response is registered when the request is taken and stays until taken.
// Occupancy in the response is the count after the request.
module sorted_priority_queue_top (
    input logic     clk,
    input logic     rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    logic       accept;
    logic       is_enq, is_deq, is_clr;
    logic       full, empty;
    cell_ctrl_t ctrl;
    cell_t      cells [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    count_t     count_reg, count_next;

    logic    rsp_valid_reg;
    status_t status_reg, status_next;
    field_t  rkey_reg, rkey_next;
    field_t  rpay_reg, rpay_next;
    count_t  occ_reg;

    // handshake
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // operation decode
    always_comb
    begin
        is_enq = 1'b0;
        is_deq = 1'b0;
        is_clr = 1'b0;
        unique case (req.operation)
            OP_ENQUEUE: is_enq = 1'b1;
            OP_DEQUEUE: is_deq = 1'b1;
            OP_COUNT:   ;
            OP_CLEAR:   is_clr = 1'b1;
            default:    ;
        endcase
    end

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // broadcast to the cells
    assign ctrl.enq     = accept && is_enq && !full;
    assign ctrl.deq     = accept && is_deq && !empty;
    assign ctrl.clr     = accept && is_clr;
    assign ctrl.key     = key_from_field(req.item_key);
    assign ctrl.payload = req.item_payload;

    // the cell chain; the head sees a filled slot in front, the tail an empty one behind
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_t left_in, right_in;
        if (i == 0)
        begin : g_head
            assign left_in = '{valid: 1'b1, gt: 1'b0, key: '0, payload: '0};
        end
        else
        begin : g_mid_l
            assign left_in = cells[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_in = '{valid: 1'b0, gt: 1'b1, key: '0, payload: '0};
        end
        else
        begin : g_mid_r
            assign right_in = cells[i+1];
        end
        spq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_in),
            .right (right_in),
            .state (cells[i])
        );
        assign valid_vec[i] = cells[i].valid;
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clr)
            count_next = '0;
        else if (ctrl.enq)
            count_next = count_reg + 1'b1;
        else if (ctrl.deq)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // response contents
    always_comb
    begin
        status_next = ST_OK;
        rkey_next   = '0;
        rpay_next   = '0;
        if (is_enq && full)
        begin
            status_next = ST_FULL;
        end
        else if (is_deq)
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                rkey_next = key_to_field(cells[0].key);
                rpay_next = cells[0].payload;
            end
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rkey_reg   <= rkey_next;
            rpay_reg   <= rpay_next;
            occ_reg    <= count_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.removed_key     = rkey_reg;
    assign rsp.removed_payload = rpay_reg;
    assign rsp.occupancy       = occ_reg;

    // count agrees with the filled cells
    a_count_cells: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_vec)))
        else $error("occupancy count does not match filled cells");

    // filled cells form a prefix of the chain
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("gap in the filled cells");

    // an empty response reports an empty queue
    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0))
        else $error("empty status with nonzero occupancy");

    // a rejected enqueue leaves the queue as it was
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_enq && full) |=> (count_reg == $past(count_reg)))
        else $error("full enqueue changed the queue");

endmodule

### rtl/spq_cell.sv
// spq_cell: one slot of the sorted chain; holds a key, a payload and a valid bit.
// Depends on spq_pkg. Shifts right on insert past it, left on dequeue.
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::cell_t      left,
    input  spq_pkg::cell_t      right,
    output spq_pkg::cell_t      state
);
    import spq_pkg::*;

    logic   valid_reg, valid_next;
    key_t   key_reg, key_next;
    field_t payload_reg, payload_next;
    logic   gt;

    // slot is behind the new key: empty, or strictly greater key (keeps ties fifo)
    assign gt = !valid_reg || (key_reg > ctrl.key);

    // next contents from the broadcast request and the neighbors
    always_comb
    begin
        valid_next   = valid_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.enq)
        begin
            if (gt)
            begin
                valid_next = left.valid;
                if (left.gt)
                begin
                    key_next     = left.key;
                    payload_next = left.payload;
                end
                else
                begin
                    key_next     = ctrl.key;
                    payload_next = ctrl.payload;
                end
            end
        end
        else if (ctrl.deq)
        begin
            valid_next   = right.valid;
            key_next     = right.key;
            payload_next = right.payload;
        end
    end

    // control bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // key and payload storage
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign state.valid   = valid_reg;
    assign state.gt      = gt;
    assign state.key     = key_reg;
    assign state.payload = payload_reg;

endmodule
